>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files. Each file that asserts has a
// clock named i_clk and a synchronous active-low reset named i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ULF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ULF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ulf_pkg.sv
// ---------------------------------------------------------------------------
// ulf_pkg
// Types, constants and lowercase/encode functions for the UTF-8 folder.
// ---------------------------------------------------------------------------
`default_nettype none

package ulf_pkg;

    localparam int CODE_W      = 21;
    localparam int QUEUE_DEPTH = 4;

    // encoded length codes (byte count minus one)
    localparam logic [1:0] LEN_1 = 2'd0;
    localparam logic [1:0] LEN_2 = 2'd1;
    localparam logic [1:0] LEN_3 = 2'd2;
    localparam logic [1:0] LEN_4 = 2'd3;

    localparam logic [CODE_W-1:0] CP_LAT_A   = 21'h41;
    localparam logic [CODE_W-1:0] CP_LAT_Z   = 21'h5A;
    localparam logic [CODE_W-1:0] CP_CYR_A   = 21'h410;
    localparam logic [CODE_W-1:0] CP_CYR_YA  = 21'h42F;
    localparam logic [CODE_W-1:0] CP_CYR_IO  = 21'h401;
    localparam logic [CODE_W-1:0] CP_CYR_YO  = 21'h451;
    localparam logic [CODE_W-1:0] CP_CYR_YE  = 21'h435;
    localparam logic [CODE_W-1:0] CP_CASE_OF = 21'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_last;
    } t_out;

    // one finished code point handed from front to back
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [1:0]        len;
        logic              eos;
    } t_ent;

    function automatic logic [CODE_W-1:0] lower_code(input logic [CODE_W-1:0] c,
                                                     input logic fold_yo);
        logic [CODE_W-1:0] r;
        r = c;
        if (c >= CP_LAT_A && c <= CP_LAT_Z) begin
            r = c + CP_CASE_OF;
        end else if (c >= CP_CYR_A && c <= CP_CYR_YA) begin
            r = c + CP_CASE_OF;
        end else if (c == CP_CYR_IO) begin
            r = CP_CYR_YO;
        end
        if (fold_yo && r == CP_CYR_YO) begin
            r = CP_CYR_YE;
        end
        return r;
    endfunction

    function automatic logic [1:0] enc_len(input logic [CODE_W-1:0] c);
        logic [1:0] l;
        if (c[CODE_W-1:7] == '0) begin
            l = LEN_1;
        end else if (c[CODE_W-1:11] == '0) begin
            l = LEN_2;
        end else if (c[CODE_W-1:16] == '0) begin
            l = LEN_3;
        end else begin
            l = LEN_4;
        end
        return l;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [CODE_W-1:0] c,
                                            input logic [1:0] len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        b = '0;
        unique case (len)
            LEN_1: b = {1'b0, c[6:0]};
            LEN_2: begin
                if (idx == 2'd0) b = {3'b110, c[10:6]};
                else             b = {2'b10, c[5:0]};
            end
            LEN_3: begin
                case (idx)
                    2'd0:    b = {4'b1110, c[15:12]};
                    2'd1:    b = {2'b10, c[11:6]};
                    default: b = {2'b10, c[5:0]};
                endcase
            end
            default: begin
                case (idx)
                    2'd0:    b = {5'b11110, c[20:18]};
                    2'd1:    b = {2'b10, c[17:12]};
                    2'd2:    b = {2'b10, c[11:6]};
                    default: b = {2'b10, c[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> src/utf8_lowercase_folder.sv
// ---------------------------------------------------------------------------
// utf8_lowercase_folder
// Lowercases a UTF-8 byte stream (Latin, Cyrillic, optional yo fold).
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_data  (t_in)
//   out      output     o_out_valid / i_out_ready  o_out_data (t_out)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_data (fold_yo)
//
// One input byte per cycle unless the front stalls; one output byte per cycle
// from the output register unless the back stalls. A finished code point
// reaches the output register through the queue and the back's entry register.
// The front stalls only when the code point queue is full; the back stalls
// only on i_out_ready. Synchronous reset clears state; fold_yo resets to 1.
// ---------------------------------------------------------------------------
`default_nettype none

module utf8_lowercase_folder
    import ulf_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data
);

    logic r_fold_yo;
    logic push;
    t_ent push_ent;
    logic q_ready;
    logic q_valid;
    t_ent q_ent;
    logic pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_yo <= 1'b1;
        end else if (i_cfg_valid) begin
            r_fold_yo <= i_cfg_data;
        end
    end

    ulf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fold_yo (r_fold_yo),
        .i_valid   (i_in_valid),
        .i_data    (i_in_data),
        .o_ready   (o_in_ready),
        .o_push    (push),
        .o_ent     (push_ent),
        .i_q_ready (q_ready)
    );

    ulf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (push_ent),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_ent   (q_ent),
        .i_pop   (pop)
    );

    ulf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_ent   (q_ent),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .o_data    (o_out_data),
        .i_ready   (i_out_ready)
    );

endmodule

`default_nettype wire

>>> src/ulf_queue.sv
// ---------------------------------------------------------------------------
// ulf_queue
// Small register FIFO of finished code points between front and back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ulf_queue
    import ulf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ent i_ent,
    output logic o_ready,
    output logic o_valid,
    output t_ent o_ent,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_ent          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_cnt != CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `ULF_ASSERT(a_q_no_overflow, !(i_push && !o_ready), "push into full queue")
    `ULF_ASSERT(a_q_cnt_range, r_cnt <= CNT_FULL, "queue count out of range")

endmodule

`default_nettype wire

>>> src/ulf_front.sv
// ---------------------------------------------------------------------------
// ulf_front
// Takes input bytes, gathers code points, lowercases finished ones and
// pushes them with their encoded length into the queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ulf_front
    import ulf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fold_yo,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_ready,
    output logic o_push,
    output t_ent o_ent,
    input  logic i_q_ready
);

    logic [CODE_W-1:0] r_code;
    logic [1:0]        r_pend;
    logic [CODE_W-1:0] n_code;
    logic [1:0]        n_pend;
    logic [CODE_W-1:0] low;
    logic              accept;
    logic              done;
    logic [7:0]        b;

    assign b       = i_data.in_byte;
    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (r_pend == 2'd0) begin
            if (!b[7]) begin
                n_code = {13'd0, b};
                n_pend = 2'd0;
            end else if (b[7:5] == 3'b110) begin
                n_code = {16'd0, b[4:0]};
                n_pend = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_code = {17'd0, b[3:0]};
                n_pend = 2'd2;
            end else begin
                // anything else, stray continuation bytes too, opens 4 bytes
                n_code = {18'd0, b[2:0]};
                n_pend = 2'd3;
            end
        end else begin
            n_code = {r_code[CODE_W-7:0], b[5:0]};
            n_pend = r_pend - 2'd1;
        end
    end

    assign done      = (n_pend == 2'd0) || i_data.end_of_string;
    assign low       = lower_code(n_code, i_fold_yo);
    assign o_push    = accept && done;
    assign o_ent.code = low;
    assign o_ent.len  = enc_len(low);
    assign o_ent.eos  = i_data.end_of_string;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code <= '0;
            r_pend <= '0;
        end else if (accept) begin
            if (done) begin
                r_code <= '0;
                r_pend <= '0;
            end else begin
                r_code <= n_code;
                r_pend <= n_pend;
            end
        end
    end

    `ULF_ASSERT_NEXT(a_fr_clear, o_push, r_pend == 2'd0, "state not cleared after push")
    `ULF_ASSERT(a_fr_no_upper, !(o_push && o_ent.code >= CP_LAT_A && o_ent.code <= CP_LAT_Z),
        "uppercase Latin letter left in output")

endmodule

`default_nettype wire

>>> src/ulf_back.sv
// ---------------------------------------------------------------------------
// ulf_back
// Pops code points from the queue and sends their UTF-8 bytes, one per
// cycle while i_ready allows, through an output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ulf_back
    import ulf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_ent i_q_ent,
    output logic o_pop,
    output logic o_valid,
    output t_out o_data,
    input  logic i_ready
);

    logic       r_act;
    t_ent       r_ent;
    logic [1:0] r_idx;
    logic       r_ovalid;
    t_out       r_out;
    logic       ld;
    logic       last;

    assign ld    = r_act && (!r_ovalid || i_ready);
    assign last  = (r_idx == r_ent.len);
    assign o_pop = i_q_valid && (!r_act || (ld && last));

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (o_pop) begin
                r_act <= 1'b1;
                r_idx <= '0;
            end else if (ld) begin
                if (last) r_act <= 1'b0;
                r_idx <= r_idx + 2'd1;
            end
            if (ld) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_ent;
        end
        if (ld) begin
            r_out.out_byte    <= enc_byte(r_ent.code, r_ent.len, r_idx);
            r_out.run_last    <= last;
            r_out.string_last <= last && r_ent.eos;
        end
    end

    `ULF_ASSERT(a_bk_idx, !r_act || r_idx <= r_ent.len, "byte index past code length")
    `ULF_ASSERT(a_bk_last, !(r_ovalid && r_out.string_last && !r_out.run_last),
        "string end not on a code point end")

endmodule

`default_nettype wire

>>> bench/tb_utf8_lowercase_folder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_utf8_lowercase_folder
// Streams UTF-8 strings into the folder through the valid/ready request
// channel and predicts every output byte from a bit-exact lowercase model.
// A scoreboard checks each output byte field by field, in order. The run uses
// directed code points, well-formed random strings, truncated strings and raw
// byte noise, with both fold_yo settings. Idling is random but for one stretch
// with none, and one receiver hold-off backs the block up.
// ---------------------------------------------------------------------------

module tb_utf8_lowercase_folder
    import ulf_pkg::*;
();

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASE_BYTES   = 92;

    // {end_of_string, byte}
    localparam logic [8:0] DIRECTED_SEQ [25] = '{
        9'h041, 9'h15A, 9'h07F,                 // Latin upper, ASCII top
        9'h0D0, 9'h081, 9'h0D0, 9'h090,         // Cyrillic IO, A
        9'h0D0, 9'h1AF, 9'h0D1, 9'h091,         // Cyrillic YA, yo
        9'h0E2, 9'h082, 9'h0AC,                 // 3-byte
        9'h0F0, 9'h09F, 9'h098, 9'h180,         // 4-byte
        9'h080, 9'h0BF, 9'h0BF, 9'h0BF,         // stray continuation as lead
        9'h0FF, 9'h1C0,                         // string ends inside a code point
        9'h1C3                                  // ends right on a 2-byte lead
    };

    class utf8_fold_scoreboard;
        logic [20:0] code_acc;
        logic [1:0]  cont_left;
        bit          yo_fold;
        t_out        expected_bytes[$];
        int          mismatches;
        int          bytes_in;
        int          bytes_out;
        int          strings_seen;

        function new();
            code_acc     = '0;
            cont_left    = '0;
            yo_fold      = 1'b1;
            mismatches   = 0;
            bytes_in     = 0;
            bytes_out    = 0;
            strings_seen = 0;
        endfunction

        function logic [20:0] fold_case(logic [20:0] c);
            logic [20:0] r;
            r = c;
            if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h410 && c <= 21'h42F)) begin
                r = c + 21'd32;
            end else if (c == 21'h401) begin
                r = 21'h451;
            end
            if (yo_fold && r == 21'h451) begin
                r = 21'h435;
            end
            return r;
        endfunction

        // one accepted input request
        function void take_byte(t_in item);
            logic [7:0]  b;
            logic [20:0] cp;
            logic [7:0]  enc [4];
            int          n;
            t_out        e;
            b = item.in_byte;
            bytes_in++;
            if (item.end_of_string) strings_seen++;
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    code_acc  = {13'd0, b};
                    cont_left = 2'd0;
                end else if (b[7:5] == 3'b110) begin
                    code_acc  = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    code_acc  = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else begin
                    code_acc  = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
            end else begin
                code_acc  = {code_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
            end
            if (cont_left != 2'd0 && !item.end_of_string) return;

            cp = fold_case(code_acc);
            if (cp < 21'h80) begin
                enc[0] = cp[7:0];
                n = 1;
            end else if (cp < 21'h800) begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
                n = 2;
            end else if (cp < 21'h10000) begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
                n = 3;
            end else begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
                n = 4;
            end
            for (int k = 0; k < n; k++) begin
                e.out_byte    = enc[k];
                e.run_last    = (k == n - 1);
                e.string_last = (k == n - 1) && item.end_of_string;
                expected_bytes = {expected_bytes, e};
            end
            code_acc  = '0;
            cont_left = '0;
        endfunction

        function void match_byte(t_out got);
            t_out want;
            bytes_out++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output byte %02h, none expected", $time,
                         got.out_byte);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte) begin
                mismatches++;
                $display("%0t: out_byte expected %02h got %02h", $time,
                         want.out_byte, got.out_byte);
            end
            if (got.run_last !== want.run_last) begin
                mismatches++;
                $display("%0t: run_last expected %0b got %0b", $time,
                         want.run_last, got.run_last);
            end
            if (got.string_last !== want.string_last) begin
                mismatches++;
                $display("%0t: string_last expected %0b got %0b", $time,
                         want.string_last, got.string_last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    t_in  in_data;
    logic out_valid;
    logic out_ready;
    t_out out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_data;

    utf8_fold_scoreboard model;
    bit  gaps_on;
    int  hold_req;
    int  stall_left;
    int  cycle_count = 0;
    int  fold_writes;

    utf8_lowercase_folder i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, model.expected_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: checks at the edge, then picks ready for the next cycle
    initial begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                model.match_byte(out_data);
            end
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (gaps_on) begin
                out_ready <= ($urandom_range(0, 99) >= 22);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        t_in item;
        item.in_byte       = b;
        item.end_of_string = eos;
        while (gaps_on && $urandom_range(0, 99) < 22) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        model.take_byte(item);
    endtask

    function automatic int utf8_len(input logic [20:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    // sends the first keep bytes of cp's encoding; eos marks the last one sent
    task automatic send_code(input logic [20:0] cp, input int keep, input logic eos);
        logic [7:0] enc [4];
        int n;
        int last;
        n = utf8_len(cp);
        case (n)
            1: enc[0] = cp[7:0];
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        last = (keep < n) ? keep - 1 : n - 1;
        for (int k = 0; k <= last; k++) begin
            send_byte(enc[k], eos && (k == last));
        end
    endtask

    function automatic logic [20:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 21'($urandom_range('h40, 'h5B));
        if (r < 30) return 21'($urandom_range(0, 'h7F));
        if (r < 36) return ($urandom_range(0, 1) != 0) ? 21'h401 : 21'h451;
        if (r < 55) return 21'($urandom_range('h3FF, 'h460));
        if (r < 70) return 21'($urandom_range('h80, 'h7FF));
        if (r < 85) return 21'($urandom_range('h800, 'hFFFF));
        return 21'($urandom_range('h10000, 'h1FFFFF));
    endfunction

    task automatic send_string();
        int mode;
        int n;
        logic [20:0] cp;
        mode = $urandom_range(0, 99);
        n    = $urandom_range(1, 6);
        if (mode < 80) begin
            for (int i = 0; i < n; i++) send_code(pick_code(), 4, i == n - 1);
        end else if (mode < 90) begin
            for (int i = 0; i < n - 1; i++) send_code(pick_code(), 4, 1'b0);
            cp = pick_code();
            while (cp < 21'h80) cp = pick_code();
            send_code(cp, $urandom_range(1, utf8_len(cp) - 1), 1'b1);
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 9) == 0));
            end
        end
    endtask

    task automatic run_strings(input int n_bytes);
        int start;
        start = model.bytes_in;
        while (model.bytes_in - start < n_bytes) send_string();
    endtask

    // sender waits until every predicted byte is out and the pipe is quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (model.expected_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_fold(input bit v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model.yo_fold = v;
        fold_writes++;
    endtask

    initial begin
        model       = new();
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = 1'b0;
        gaps_on     = 1'b1;
        hold_req    = 0;
        fold_writes = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, fold_yo at its reset value
        for (int i = 0; i < 25; i++) begin
            send_byte(DIRECTED_SEQ[i][7:0], DIRECTED_SEQ[i][8]);
        end
        write_fold(1'b0);
        send_byte(8'hD1, 1'b0);
        send_byte(8'h91, 1'b1);
        send_byte(8'hD0, 1'b0);
        send_byte(8'h81, 1'b1);
        run_strings(PHASE_BYTES);

        // receiver holds off while the sender keeps pushing
        write_fold(1'b1);
        hold_req = HOLD_CYCLES;
        run_strings(PHASE_BYTES);

        // long stretch with no idling on either side
        write_fold(1'b0);
        gaps_on = 1'b0;
        run_strings(PHASE_BYTES);
        gaps_on = 1'b1;

        write_fold(1'b1);
        run_strings(PHASE_BYTES);

        settle();
        repeat (10) @(posedge clk);
        $display("Folded %0d input bytes in %0d strings into %0d output bytes;",
                 model.bytes_in, model.strings_seen, model.bytes_out);
        $display("fold_yo written %0d times, one %0d-cycle receiver hold-off.",
                 fold_writes, HOLD_CYCLES);
        if (model.mismatches == 0 && model.expected_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
